FILE: rtl/sched_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sched_pkg: shared types and constants of the process scheduler
// Slot table sizing, datapath widths, codes and the structs that pass
// between the sequencer, the table memory and the arithmetic unit.
// ----------------------------------------------------------------------------
package sched_pkg;

	localparam int MAX_PROCESSES = 16;
	localparam int CLOCK_BITS    = 16;

	localparam int SLOT_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CNT_W   = $clog2(MAX_PROCESSES + 1);
	localparam int WGT_W   = 8;
	localparam int RND_W   = 16;
	localparam int DIV_W   = $clog2(RND_W);
	localparam int SUM_W   = $clog2(MAX_PROCESSES * ((1 << WGT_W) - 1) + 1);
	localparam int ALU_W   = (CLOCK_BITS > SUM_W + 1) ? CLOCK_BITS : SUM_W + 1;
	localparam int TS_W    = 8;
	localparam int POL_W   = 2;
	localparam int MODE_W  = 2;

	// stream and register port widths (fixed by the item layout)
	localparam int IN_W    = 48;
	localparam int OUT_W   = 8;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [CLOCK_BITS-1:0] clk_t;
	typedef logic [WGT_W-1:0]      wgt_t;
	typedef logic [SUM_W-1:0]      sum_t;
	typedef logic [ALU_W-1:0]      alu_t;
	typedef logic [TS_W-1:0]       ts_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD    = 2'd0,
		MODE_TICK    = 2'd1,
		MODE_RESTART = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	typedef enum logic [POL_W-1:0] {
		POL_PRIO = 2'd0,
		POL_RR   = 2'd1,
		POL_LOT  = 2'd2
	} policy_t;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_SLICE  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_DIV,
		ST_RR,
		ST_RUN_RD,
		ST_RUN_INC,
		ST_RUN_CMP,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		SK_PRIO,
		SK_SUM,
		SK_LOT
	} scan_kind_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		alu_t    a;
		alu_t    b;
	} alu_req_t;

	typedef struct packed {
		alu_t y;
		logic carry;     // add: overflow, sub: a >= b
	} alu_rsp_t;

	typedef struct packed {
		logic  tbl_we;
		logic  exec_we;
		slot_t addr;
		clk_t  total;
		wgt_t  weight;
		clk_t  exec;
	} mem_wr_t;

	typedef struct packed {
		clk_t total;
		clk_t exec;
		wgt_t weight;
	} mem_rd_t;

	typedef struct packed {
		logic       pad;
		logic       all_done;
		logic       fin;
		logic [3:0] slot;
		logic       ran;
	} result_t;

	function automatic slot_t slot_inc(input slot_t s);
		slot_t r;
		if (s == slot_t'(MAX_PROCESSES - 1)) begin
			r = '0;
		end else begin
			r = slot_t'(s + 1'b1);
		end
		return r;
	endfunction

endpackage

FILE: rtl/sched_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sched_alu: shared add/subtract unit
// One adder used by every scan, the remainder steps and the clock update.
// ----------------------------------------------------------------------------
module sched_alu (
	input  sched_pkg::alu_req_t req,
	output sched_pkg::alu_rsp_t rsp
);

	logic                       sub;
	logic [sched_pkg::ALU_W-1:0] b_in;
	logic [sched_pkg::ALU_W:0]   total;

	assign sub   = (req.op == sched_pkg::ALU_SUB);
	assign b_in  = sub ? ~req.b : req.b;
	assign total = {1'b0, req.a} + {1'b0, b_in} + {{sched_pkg::ALU_W{1'b0}}, sub};

	assign rsp.y     = total[sched_pkg::ALU_W-1:0];
	assign rsp.carry = total[sched_pkg::ALU_W];

endmodule

FILE: rtl/sched_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sched_mem: process slot tables
// Total clocks, clocks run and weight per slot; one write address, one
// registered read port.
// ----------------------------------------------------------------------------
module sched_mem (
	input  logic               clk,
	input  sched_pkg::mem_wr_t wr,
	input  sched_pkg::slot_t   raddr,
	output sched_pkg::mem_rd_t rd
);

	sched_pkg::clk_t total_mem  [sched_pkg::MAX_PROCESSES];
	sched_pkg::clk_t exec_mem   [sched_pkg::MAX_PROCESSES];
	sched_pkg::wgt_t weight_mem [sched_pkg::MAX_PROCESSES];

	always_ff @(posedge clk) begin
		if (wr.tbl_we) begin
			total_mem[wr.addr]  <= wr.total;
			weight_mem[wr.addr] <= wr.weight;
		end
		if (wr.exec_we) begin
			exec_mem[wr.addr] <= wr.exec;
		end
		rd.total  <= total_mem[raddr];
		rd.exec   <= exec_mem[raddr];
		rd.weight <= weight_mem[raddr];
	end

endmodule

FILE: rtl/multi_policy_process_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_policy_process_scheduler: priority / round-robin / lottery scheduler
// Holds a table of process slots and runs one clock of one process per tick
// beat, choosing it by the policy register. All table work goes through one
// shared adder under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  dir  signals                         beat contents
//  s_axis   in   tvalid tready tdata[47:0] tuser  one command (load/tick/restart/clear)
//  m_axis   out  tvalid tready tdata[7:0]         one result per command
//  apb      in   psel penable pwrite paddr ...    policy @0x0, time_slice @0x4
//
//  Per command (N = slot count, 16 here): load, restart, clear: no scan.
//    Priority tick: one scan of N slots. Round-robin tick: no search while
//    a slice continues, up to N slots searched for a new slice. Lottery
//    tick starting a slice: sum scan, 16-step remainder, draw scan, bound
//    by the single table read port and the shared adder.
//  Reset clears slot valid bits and slice state at once; no clearing pass.
//  A result waits in the output register; the next command is taken while
//  it waits, and the sequencer stalls in its final state until it drains.
//
module multi_policy_process_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	// command stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata: slot[3:0], total_clocks[19:4], weight[27:20], random_value[43:28], zero
	input  logic [sched_pkg::IN_W-1:0]    s_axis_tdata,
	// tuser: mode[1:0]
	input  logic [sched_pkg::MODE_W-1:0]  s_axis_tuser,
	// result stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tdata: ran_valid[0], ran_slot[4:1], slot_finished[5], all_done[6], zero[7]
	output logic [sched_pkg::OUT_W-1:0]   m_axis_tdata,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sched_pkg::PADDR_W-1:0] paddr,
	input  logic [sched_pkg::PDATA_W-1:0] pwdata,
	output logic [sched_pkg::PDATA_W-1:0] prdata,
	output logic                          pready
);

	localparam int N = sched_pkg::MAX_PROCESSES;

	// command fields
	sched_pkg::mode_t  mode_in;
	logic [3:0]        slot_in;
	logic [15:0]       tot_in;
	sched_pkg::wgt_t   wgt_in;
	logic [15:0]       rnd_in;
	logic              slot_ok;
	sched_pkg::slot_t  slot_idx;
	sched_pkg::clk_t   tot_clk;
	logic              accept;

	assign mode_in  = sched_pkg::mode_t'(s_axis_tuser);
	assign slot_in  = s_axis_tdata[3:0];
	assign tot_in   = s_axis_tdata[19:4];
	assign wgt_in   = s_axis_tdata[27:20];
	assign rnd_in   = s_axis_tdata[43:28];
	assign slot_ok  = (32'(slot_in) < N);
	assign slot_idx = sched_pkg::slot_t'(slot_in);
	assign tot_clk  = sched_pkg::clk_t'(tot_in);
	assign accept   = s_axis_tvalid && s_axis_tready;

	// registers
	sched_pkg::state_t     state_q, state_d;
	logic [sched_pkg::POL_W-1:0] policy_q;
	sched_pkg::ts_t        tslice_q;
	logic [N-1:0]          valid_q;   // slot loaded
	logic [N-1:0]          done_q;    // clocks run reached total
	logic [N-1:0]          nz_q;      // total is nonzero
	logic [N-1:0]          ez_q;      // clocks run reads as zero (after load/restart)
	sched_pkg::slot_t      cur_q;
	sched_pkg::ts_t        slice_cnt_q;
	logic                  slice_act_q;
	sched_pkg::scan_kind_t scan_kind_q;
	sched_pkg::cnt_t       cnt_q;
	sched_pkg::slot_t      idx_s1;
	sched_pkg::slot_t      rr_idx_q;
	sched_pkg::wgt_t       best_w_q;
	logic                  have_q;
	sched_pkg::sum_t       sum_q;
	sched_pkg::sum_t       rem_q;
	logic [sched_pkg::RND_W-1:0] rnd_q;
	logic [sched_pkg::DIV_W-1:0] div_cnt_q;
	sched_pkg::slot_t      pick_q;
	sched_pkg::clk_t       exec_new_q;
	sched_pkg::clk_t       total_q;
	logic                  res_ran_q;
	logic                  res_fin_q;
	logic                  m_valid_q;
	sched_pkg::result_t    m_data_q;

	// shared units
	sched_pkg::alu_req_t alu_req;
	sched_pkg::alu_rsp_t alu_rsp;
	sched_pkg::mem_wr_t  mem_wr;
	sched_pkg::mem_rd_t  mem_rd;
	sched_pkg::slot_t    raddr;

	sched_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	sched_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.raddr (raddr),
		.rd    (mem_rd)
	);

	// derived status
	logic [N-1:0]     un;
	sched_pkg::ts_t   ts_eff;
	sched_pkg::ts_t   cnt_new;
	logic             cont;
	logic             scan_last;
	logic             scan_proc;
	logic             el_un;
	sched_pkg::clk_t  exec_old;
	logic             fin_go;
	logic             cfg_wr;
	logic             run_fin;
	logic             slice_end;

	assign un        = valid_q & ~done_q;
	assign ts_eff    = (tslice_q == '0) ? sched_pkg::ts_t'(1) : tslice_q;
	assign cnt_new   = sched_pkg::ts_t'(slice_cnt_q + 1'b1);
	assign cont      = slice_act_q && un[cur_q] && (slice_cnt_q < ts_eff);
	assign scan_last = (cnt_q == sched_pkg::cnt_t'(N));
	assign scan_proc = (cnt_q != '0);
	assign el_un     = un[idx_s1];
	assign exec_old  = ez_q[pick_q] ? '0 : mem_rd.exec;
	assign fin_go    = !m_valid_q || m_axis_tready;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign run_fin   = alu_rsp.carry;  // clocks run >= total in the compare step
	assign slice_end = run_fin || (cnt_new >= ts_eff);

	// sequencer: next state, table read address, adder and table writes
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		raddr         = pick_q;
		alu_req.op    = sched_pkg::ALU_ADD;
		alu_req.a     = '0;
		alu_req.b     = '0;
		mem_wr        = '0;
		case (state_q)
			sched_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				mem_wr.addr   = slot_idx;
				mem_wr.total  = tot_clk;
				mem_wr.weight = wgt_in;
				if (accept) begin
					state_d = sched_pkg::ST_FIN;
					case (mode_in)
						sched_pkg::MODE_LOAD: begin
							mem_wr.tbl_we = slot_ok;
						end
						sched_pkg::MODE_TICK: begin
							case (policy_q)
								sched_pkg::POL_PRIO: state_d = sched_pkg::ST_SCAN;
								sched_pkg::POL_RR: begin
									state_d = cont ? sched_pkg::ST_RUN_RD : sched_pkg::ST_RR;
								end
								sched_pkg::POL_LOT: begin
									state_d = cont ? sched_pkg::ST_RUN_RD : sched_pkg::ST_SCAN;
								end
								default: state_d = sched_pkg::ST_FIN;
							endcase
						end
						default: state_d = sched_pkg::ST_FIN;
					endcase
				end
			end
			sched_pkg::ST_SCAN: begin
				raddr = cnt_q[sched_pkg::SLOT_W-1:0];
				case (scan_kind_q)
					sched_pkg::SK_PRIO: begin
						alu_req.op = sched_pkg::ALU_SUB;
						alu_req.a  = sched_pkg::alu_t'(best_w_q);
					end
					sched_pkg::SK_SUM: begin
						alu_req.op = sched_pkg::ALU_ADD;
						alu_req.a  = sched_pkg::alu_t'(sum_q);
					end
					default: begin
						alu_req.op = sched_pkg::ALU_SUB;
						alu_req.a  = sched_pkg::alu_t'(rem_q);
					end
				endcase
				alu_req.b = sched_pkg::alu_t'(mem_rd.weight);
				if (scan_last) begin
					state_d = sched_pkg::ST_DECIDE;
				end
			end
			sched_pkg::ST_DECIDE: begin
				case (scan_kind_q)
					sched_pkg::SK_SUM: begin
						state_d = (sum_q == '0) ? sched_pkg::ST_FIN : sched_pkg::ST_DIV;
					end
					default: begin
						state_d = have_q ? sched_pkg::ST_RUN_RD : sched_pkg::ST_FIN;
					end
				endcase
			end
			sched_pkg::ST_DIV: begin
				// restoring remainder step: shift in the next bit, subtract if it fits
				alu_req.op = sched_pkg::ALU_SUB;
				alu_req.a  = sched_pkg::alu_t'({rem_q, rnd_q[div_cnt_q]});
				alu_req.b  = sched_pkg::alu_t'(sum_q);
				if (div_cnt_q == '0) begin
					state_d = sched_pkg::ST_SCAN;
				end
			end
			sched_pkg::ST_RR: begin
				if (un[rr_idx_q]) begin
					state_d = sched_pkg::ST_RUN_RD;
				end else if (cnt_q == sched_pkg::cnt_t'(N - 1)) begin
					state_d = sched_pkg::ST_FIN;
				end
			end
			sched_pkg::ST_RUN_RD: begin
				state_d = sched_pkg::ST_RUN_INC;
			end
			sched_pkg::ST_RUN_INC: begin
				alu_req.op     = sched_pkg::ALU_ADD;
				alu_req.a      = sched_pkg::alu_t'(exec_old);
				alu_req.b      = sched_pkg::alu_t'(1);
				mem_wr.exec_we = 1'b1;
				mem_wr.addr    = pick_q;
				mem_wr.exec    = alu_rsp.y[sched_pkg::CLOCK_BITS-1:0];
				state_d        = sched_pkg::ST_RUN_CMP;
			end
			sched_pkg::ST_RUN_CMP: begin
				alu_req.op = sched_pkg::ALU_SUB;
				alu_req.a  = sched_pkg::alu_t'(exec_new_q);
				alu_req.b  = sched_pkg::alu_t'(total_q);
				state_d    = sched_pkg::ST_FIN;
			end
			sched_pkg::ST_FIN: begin
				if (fin_go) begin
					state_d = sched_pkg::ST_IDLE;
				end
			end
			default: state_d = sched_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sched_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state: registers, slot flags, slice bookkeeping, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= sched_pkg::POL_PRIO;
			tslice_q    <= sched_pkg::ts_t'(1);
			valid_q     <= '0;
			cur_q       <= '0;
			slice_cnt_q <= '0;
			slice_act_q <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == sched_pkg::REG_POLICY) begin
					policy_q <= pwdata[sched_pkg::POL_W-1:0];
				end else begin
					tslice_q <= pwdata[sched_pkg::TS_W-1:0];
				end
			end

			if (accept) begin
				case (mode_in)
					sched_pkg::MODE_LOAD: begin
						if (slot_ok) begin
							valid_q[slot_idx] <= 1'b1;
						end
					end
					sched_pkg::MODE_TICK: begin
						// undefined policy leaves the slice untouched
						if (policy_q == sched_pkg::POL_PRIO
								|| ((policy_q == sched_pkg::POL_RR
								|| policy_q == sched_pkg::POL_LOT) && !cont)) begin
							slice_act_q <= 1'b0;
							slice_cnt_q <= '0;
						end
					end
					sched_pkg::MODE_RESTART: begin
						slice_act_q <= 1'b0;
						slice_cnt_q <= '0;
					end
					default: begin
						valid_q     <= '0;
						slice_act_q <= 1'b0;
						slice_cnt_q <= '0;
						cur_q       <= '0;
					end
				endcase
			end

			// new slice found
			if (state_q == sched_pkg::ST_RR && un[rr_idx_q]) begin
				slice_act_q <= 1'b1;
				cur_q       <= rr_idx_q;
			end
			if (state_q == sched_pkg::ST_DECIDE && scan_kind_q == sched_pkg::SK_LOT
					&& have_q) begin
				slice_act_q <= 1'b1;
				cur_q       <= pick_q;
			end

			if (state_q == sched_pkg::ST_RUN_CMP) begin
				if (policy_q == sched_pkg::POL_PRIO) begin
					cur_q <= pick_q;
				end else if (slice_end) begin
					slice_act_q <= 1'b0;
					slice_cnt_q <= '0;
					if (policy_q == sched_pkg::POL_RR) begin
						cur_q <= sched_pkg::slot_inc(pick_q);
					end
				end else begin
					slice_cnt_q <= cnt_new;
				end
			end

			if (state_q == sched_pkg::ST_FIN && fin_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath: scan accumulators, remainder, pick, per-slot flags, result
	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q       <= '0;
			have_q      <= 1'b0;
			sum_q       <= '0;
			rem_q       <= '0;
			rnd_q       <= rnd_in;
			div_cnt_q   <= sched_pkg::DIV_W'(sched_pkg::RND_W - 1);
			rr_idx_q    <= cur_q;
			pick_q      <= cur_q;
			res_ran_q   <= 1'b0;
			res_fin_q   <= 1'b0;
			scan_kind_q <= (policy_q == sched_pkg::POL_PRIO) ? sched_pkg::SK_PRIO
			                                                 : sched_pkg::SK_SUM;
			case (mode_in)
				sched_pkg::MODE_LOAD: begin
					if (slot_ok) begin
						done_q[slot_idx] <= (tot_clk == '0);
						nz_q[slot_idx]   <= (tot_clk != '0);
						ez_q[slot_idx]   <= 1'b1;
					end
				end
				sched_pkg::MODE_RESTART: begin
					ez_q   <= '1;
					done_q <= ~nz_q;
				end
				default: ;
			endcase
		end

		case (state_q)
			sched_pkg::ST_SCAN: begin
				cnt_q  <= sched_pkg::cnt_t'(cnt_q + 1'b1);
				idx_s1 <= cnt_q[sched_pkg::SLOT_W-1:0];
				if (scan_proc && el_un) begin
					case (scan_kind_q)
						sched_pkg::SK_PRIO: begin
							// strictly greater weight wins, so ties stay with the lower slot
							if (!have_q || !alu_rsp.carry) begin
								have_q   <= 1'b1;
								best_w_q <= mem_rd.weight;
								pick_q   <= idx_s1;
							end
						end
						sched_pkg::SK_SUM: begin
							sum_q <= alu_rsp.y[sched_pkg::SUM_W-1:0];
						end
						default: begin
							if (!have_q) begin
								if (!alu_rsp.carry) begin
									have_q <= 1'b1;
									pick_q <= idx_s1;
								end else begin
									rem_q <= alu_rsp.y[sched_pkg::SUM_W-1:0];
								end
							end
						end
					endcase
				end
			end
			sched_pkg::ST_DIV: begin
				if (alu_rsp.carry) begin
					rem_q <= alu_rsp.y[sched_pkg::SUM_W-1:0];
				end else begin
					rem_q <= {rem_q[sched_pkg::SUM_W-2:0], rnd_q[div_cnt_q]};
				end
				div_cnt_q <= sched_pkg::DIV_W'(div_cnt_q - 1'b1);
				if (div_cnt_q == '0) begin
					scan_kind_q <= sched_pkg::SK_LOT;
					cnt_q       <= '0;
					have_q      <= 1'b0;
				end
			end
			sched_pkg::ST_RR: begin
				if (un[rr_idx_q]) begin
					pick_q <= rr_idx_q;
				end else begin
					rr_idx_q <= sched_pkg::slot_inc(rr_idx_q);
					cnt_q    <= sched_pkg::cnt_t'(cnt_q + 1'b1);
				end
			end
			sched_pkg::ST_RUN_INC: begin
				exec_new_q   <= alu_rsp.y[sched_pkg::CLOCK_BITS-1:0];
				total_q      <= mem_rd.total;
				ez_q[pick_q] <= 1'b0;
			end
			sched_pkg::ST_RUN_CMP: begin
				done_q[pick_q] <= run_fin;
				res_ran_q      <= 1'b1;
				res_fin_q      <= run_fin;
			end
			sched_pkg::ST_FIN: begin
				if (fin_go) begin
					m_data_q.pad      <= 1'b0;
					m_data_q.all_done <= ~|un;
					m_data_q.fin      <= res_fin_q;
					m_data_q.slot     <= res_ran_q ? 4'(pick_q) : 4'd0;
					m_data_q.ran      <= res_ran_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign pready        = 1'b1;
	assign prdata        = (paddr[2] == sched_pkg::REG_SLICE)
	                       ? sched_pkg::PDATA_W'(tslice_q)
	                       : sched_pkg::PDATA_W'(policy_q);

	// one command at a time: the sequencer leaves idle after every accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("command accepted while sequencer busy");

	a_slice_count: assert property (@(posedge clk) disable iff (!arst_n)
		(slice_cnt_q != '0) |-> slice_act_q)
		else $error("slice count without active slice");

	a_slice_slot: assert property (@(posedge clk) disable iff (!arst_n)
		slice_act_q |-> valid_q[cur_q])
		else $error("active slice on an empty slot");

	a_draw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sched_pkg::ST_SCAN && scan_kind_q == sched_pkg::SK_LOT)
		|-> (rem_q < sum_q))
		else $error("lottery draw not below ticket sum");

	a_run_unfinished: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sched_pkg::ST_RUN_CMP) |-> un[pick_q])
		else $error("finished or empty slot chosen to run");

endmodule
